[rtl/satpc_pkg.sv]
package satpc_pkg;

    localparam int DEF_MAX_VERTICES = 8;
    localparam int AXIS_FRAC        = 30;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_APPEND_A = 2'd1,
        ACT_APPEND_B = 2'd2,
        ACT_TEST     = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E_RD0,
        ST_E_RD1,
        ST_E_DIFF,
        ST_NORM,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_P_RD,
        ST_P_M1,
        ST_P_M2,
        ST_P_M3,
        ST_P_ACC,
        ST_CMP,
        ST_S_M1,
        ST_S_M2,
        ST_S_M3,
        ST_S_RND
    } t_state;

endpackage

[rtl/satpc_ram.sv]
module satpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

[rtl/sat_polygon_collision.sv]
// Channel   | Handshake        | Payload
// ----------+------------------+------------------------------------------------
// command   | i_start, o_busy  | i_action, i_vertex_x, i_vertex_y
// result    | o_valid (strobe) | o_collided, o_mtv_x, o_mtv_y, o_min_axis,
//           |                  | o_bad_input
//
// A command transaction completes on an edge with i_start high and o_busy low.
// Clear and append give no result. A test with too few vertices answers in the
// cycle after it is taken; otherwise each axis reads its edge, normalizes the
// normal by shifts, squares and sums its components, takes the square root,
// divides both components by it and projects every vertex of both polygons,
// then compares, all on one shared 34x34 multiplier and one vertex RAM port per
// polygon; a zero-length edge skips the root and the division. The first gap
// ends a test early.
// Reset (synchronous, active low) clears counts, overflow flag, FSM and strobe;
// the vertex RAMs keep their contents. Results show for exactly one cycle.
module sat_polygon_collision
    import satpc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_vertex_x,
    input  logic [31:0] i_vertex_y,
    output logic        o_valid,
    output logic        o_collided,
    output logic [31:0] o_mtv_x,
    output logic [31:0] o_mtv_y,
    output logic [3:0]  o_min_axis,
    output logic        o_bad_input
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(2 * MAX_VERTICES);
    localparam logic [CW-1:0] MAXC    = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] MIN_CNT = CW'(3);
    localparam logic signed [67:0] HALF_Q = 68'sd1 <<< (AXIS_FRAC - 1);

    // control state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt_a, r_cnt_b;
    logic           r_ovf;
    logic           r_o_valid;

    // edge / axis walk
    logic           r_epoly;
    logic [VW-1:0]  r_eidx;
    logic [IW-1:0]  r_axis;
    logic signed [31:0] r_px, r_py;
    logic [33:0]    r_a, r_b;
    logic           r_nxneg, r_nyneg;

    // sqrt and division
    logic [63:0]    r_x, r_res, r_bit;
    logic [61:0]    r_num_a, r_num_b, r_dsr;
    logic [30:0]    r_qa, r_qb;
    logic [4:0]     r_k;
    logic signed [31:0] r_ux, r_uy;

    // projection
    logic           r_psel;
    logic [VW-1:0]  r_vi;
    logic signed [31:0] r_vy;
    logic signed [67:0] r_prod, r_acc;
    logic signed [34:0] r_lo_a, r_hi_a, r_lo_b, r_hi_b;

    // best axis
    logic [35:0]    r_best_ov;
    logic [IW-1:0]  r_best_idx;
    logic signed [31:0] r_best_ux, r_best_uy;
    logic           r_best_isb;
    logic           r_comp;
    logic [31:0]    r_mtv_x;

    // result register
    logic           r_o_coll, r_o_bad;
    logic [31:0]    r_o_mx, r_o_my;
    logic [3:0]     r_o_ax;

    t_action        act;
    logic           accept;
    logic           too_few;

    assign act     = t_action'(i_action);
    assign accept  = i_start && (r_state == ST_IDLE);
    assign too_few = (r_cnt_a < MIN_CNT) || (r_cnt_b < MIN_CNT);

    // vertex RAMs: {x, y}
    logic [VW-1:0]  ram_addr;
    logic           we_a, we_b;
    logic [63:0]    rd_a, rd_b, rd;
    logic           rd_sel_b;
    logic signed [31:0] rd_x, rd_y;

    logic [CW-1:0]  e_n, e_nxt, p_n, p_nxt;
    logic           e_last, p_last;
    logic [VW-1:0]  e_j;

    assign e_n    = r_epoly ? r_cnt_b : r_cnt_a;
    assign e_nxt  = CW'(r_eidx) + CW'(1);
    assign e_last = (e_nxt == e_n);
    assign e_j    = e_last ? '0 : e_nxt[VW-1:0];
    assign p_n    = r_psel ? r_cnt_b : r_cnt_a;
    assign p_nxt  = CW'(r_vi) + CW'(1);
    assign p_last = (p_nxt == p_n);

    assign we_a = accept && (act == ACT_APPEND_A) && (r_cnt_a < MAXC);
    assign we_b = accept && (act == ACT_APPEND_B) && (r_cnt_b < MAXC);

    always_comb begin
        case (r_state)
            ST_IDLE:  ram_addr = (act == ACT_APPEND_B) ? r_cnt_b[VW-1:0] : r_cnt_a[VW-1:0];
            ST_E_RD0: ram_addr = r_eidx;
            ST_E_RD1: ram_addr = e_j;
            default:  ram_addr = r_vi;
        endcase
    end

    satpc_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_addr  (ram_addr),
        .i_wdata ({i_vertex_x, i_vertex_y}),
        .o_rdata (rd_a)
    );

    satpc_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_addr  (ram_addr),
        .i_wdata ({i_vertex_x, i_vertex_y}),
        .o_rdata (rd_b)
    );

    assign rd_sel_b = (r_state inside {ST_E_RD1, ST_E_DIFF}) ? r_epoly : r_psel;
    assign rd       = rd_sel_b ? rd_b : rd_a;
    assign rd_x     = signed'(rd[63:32]);
    assign rd_y     = signed'(rd[31:0]);

    // edge normal, exact in 33 bits
    logic signed [32:0] nx, ny;
    assign nx = {rd_y[31], rd_y} - {r_py[31], r_py};
    assign ny = {r_px[31], r_px} - {rd_x[31], rd_x};

    // normalization window [2^30, 2^31)
    logic [33:0] m;
    logic        m_zero, m_big, m_small;
    assign m       = (r_a > r_b) ? r_a : r_b;
    assign m_zero  = (m == '0);
    assign m_big   = (m[33:31] != '0);
    assign m_small = (m[33:30] == '0);

    // one restoring sqrt step
    logic [63:0] sq_t;
    logic        sq_ge;
    assign sq_t  = r_res + r_bit;
    assign sq_ge = (r_x >= sq_t);

    // one division step for each component
    logic ge_a, ge_b;
    logic [30:0] qa_n, qb_n;
    assign ge_a = (r_num_a >= r_dsr);
    assign ge_b = (r_num_b >= r_dsr);
    assign qa_n = {r_qa[29:0], ge_a};
    assign qb_n = {r_qb[29:0], ge_b};

    // projection rounding: floor((dot + 2^29) / 2^30)
    logic signed [67:0] rnd;
    logic signed [34:0] proj;
    assign rnd  = r_acc + HALF_Q;
    assign proj = rnd[64:30];

    // overlap test
    logic signed [35:0] d1, d2, ov_c;
    logic               apart;
    assign d1    = {r_hi_a[34], r_hi_a} - {r_lo_b[34], r_lo_b};
    assign d2    = {r_hi_b[34], r_hi_b} - {r_lo_a[34], r_lo_a};
    assign ov_c  = (d1 < d2) ? d1 : d2;
    assign apart = (r_hi_a < r_lo_b) || (r_hi_b < r_lo_a);

    // translation vector scaling
    logic signed [31:0] u_sel;
    logic [30:0]        mag;
    logic               neg;
    logic [37:0]        s_mag;
    logic [31:0]        s_val;
    assign u_sel = r_comp ? r_best_uy : r_best_ux;
    assign mag   = u_sel[31] ? 31'(-u_sel) : u_sel[30:0];
    assign neg   = u_sel[31] ^ r_best_isb;
    assign s_mag = rnd[67:30];

    always_comb begin
        if (neg) begin
            s_val = (s_mag > 38'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - s_mag[31:0]);
        end else begin
            s_val = (s_mag > 38'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : s_mag[31:0];
        end
    end

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    always_comb begin
        case (r_state)
            ST_SQ1: begin
                mul_a = signed'(r_a);
                mul_b = signed'(r_a);
            end
            ST_SQ2: begin
                mul_a = signed'(r_b);
                mul_b = signed'(r_b);
            end
            ST_P_M1: begin
                mul_a = 34'(r_ux);
                mul_b = 34'(rd_x);
            end
            ST_P_M2: begin
                mul_a = 34'(r_uy);
                mul_b = 34'(r_vy);
            end
            ST_S_M1: begin
                mul_a = signed'({2'b00, r_best_ov[31:0]});
                mul_b = signed'({3'b000, mag});
            end
            ST_S_M2: begin
                mul_a = signed'({30'd0, r_best_ov[35:32]});
                mul_b = signed'({3'b000, mag});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (act == ACT_TEST) && !too_few) begin
                    n_state = ST_E_RD0;
                end
            end
            ST_E_RD0:  n_state = ST_E_RD1;
            ST_E_RD1:  n_state = ST_E_DIFF;
            ST_E_DIFF: n_state = ST_NORM;
            ST_NORM: begin
                if (m_zero) begin
                    n_state = ST_P_RD;
                end else if (!m_big && !m_small) begin
                    n_state = ST_SQ1;
                end
            end
            ST_SQ1:   n_state = ST_SQ2;
            ST_SQ2:   n_state = ST_SQ3;
            ST_SQ3:   n_state = ST_SQRT;
            ST_SQRT:  n_state = r_bit[0] ? ST_DINIT : ST_SQRT;
            ST_DINIT: n_state = ST_DIV;
            ST_DIV:   n_state = (r_k == 5'd0) ? ST_P_RD : ST_DIV;
            ST_P_RD:  n_state = ST_P_M1;
            ST_P_M1:  n_state = ST_P_M2;
            ST_P_M2:  n_state = ST_P_M3;
            ST_P_M3:  n_state = ST_P_ACC;
            ST_P_ACC: n_state = (p_last && r_psel) ? ST_CMP : ST_P_RD;
            ST_CMP: begin
                if (apart) begin
                    n_state = ST_IDLE;
                end else if (e_last && r_epoly) begin
                    n_state = ST_S_M1;
                end else begin
                    n_state = ST_E_RD0;
                end
            end
            ST_S_M1:  n_state = ST_S_M2;
            ST_S_M2:  n_state = ST_S_M3;
            ST_S_M3:  n_state = ST_S_RND;
            ST_S_RND: n_state = r_comp ? ST_IDLE : ST_S_M1;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= (accept && (act == ACT_TEST) && too_few)
                      || ((r_state == ST_CMP) && apart)
                      || ((r_state == ST_S_RND) && r_comp);
            if (accept) begin
                case (act)
                    ACT_CLEAR: begin
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_ovf   <= 1'b0;
                    end
                    ACT_APPEND_A: begin
                        if (we_a) r_cnt_a <= r_cnt_a + CW'(1);
                        else      r_ovf   <= 1'b1;
                    end
                    ACT_APPEND_B: begin
                        if (we_b) r_cnt_b <= r_cnt_b + CW'(1);
                        else      r_ovf   <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath
    logic [IW+3:0] ax_ext;
    assign ax_ext = (IW + 4)'(r_best_idx);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                r_epoly  <= 1'b0;
                r_eidx   <= '0;
                r_axis   <= '0;
                r_o_coll <= 1'b0;
                r_o_mx   <= '0;
                r_o_my   <= '0;
                r_o_ax   <= '0;
                r_o_bad  <= 1'b1;
            end
            ST_E_RD1: begin
                r_px <= rd_x;
                r_py <= rd_y;
            end
            ST_E_DIFF: begin
                r_nxneg <= nx[32];
                r_nyneg <= ny[32];
                r_a     <= nx[32] ? -{nx[32], nx} : {nx[32], nx};
                r_b     <= ny[32] ? -{ny[32], ny} : {ny[32], ny};
            end
            ST_NORM: begin
                r_psel <= 1'b0;
                r_vi   <= '0;
                if (m_zero) begin
                    r_ux <= '0;
                    r_uy <= '0;
                end else if (m_big) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                end else if (m_small) begin
                    r_a <= r_a << 1;
                    r_b <= r_b << 1;
                end
            end
            ST_SQ2: r_acc <= r_prod;
            ST_SQ3: begin
                r_x   <= r_acc[63:0] + r_prod[63:0];
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_x   <= r_x - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DINIT: begin
                r_num_a <= {1'b0, r_a[30:0], 30'd0} + 62'(r_res[31:1]);
                r_num_b <= {1'b0, r_b[30:0], 30'd0} + 62'(r_res[31:1]);
                r_dsr   <= {r_res[31:0], 30'd0};
                r_qa    <= '0;
                r_qb    <= '0;
                r_k     <= 5'd30;
            end
            ST_DIV: begin
                if (ge_a) r_num_a <= r_num_a - r_dsr;
                if (ge_b) r_num_b <= r_num_b - r_dsr;
                r_qa  <= qa_n;
                r_qb  <= qb_n;
                r_dsr <= r_dsr >> 1;
                r_k   <= r_k - 5'd1;
                if (r_k == 5'd0) begin
                    r_ux <= r_nxneg ? -signed'({1'b0, qa_n}) : signed'({1'b0, qa_n});
                    r_uy <= r_nyneg ? -signed'({1'b0, qb_n}) : signed'({1'b0, qb_n});
                end
            end
            ST_P_M1: r_vy  <= rd_y;
            ST_P_M2: r_acc <= r_prod;
            ST_P_M3: r_acc <= r_acc + r_prod;
            ST_P_ACC: begin
                if (r_psel) begin
                    if ((r_vi == '0) || (proj < r_lo_b)) r_lo_b <= proj;
                    if ((r_vi == '0) || (proj > r_hi_b)) r_hi_b <= proj;
                end else begin
                    if ((r_vi == '0) || (proj < r_lo_a)) r_lo_a <= proj;
                    if ((r_vi == '0) || (proj > r_hi_a)) r_hi_a <= proj;
                end
                if (p_last) begin
                    r_psel <= 1'b1;
                    r_vi   <= '0;
                end else begin
                    r_vi <= p_nxt[VW-1:0];
                end
            end
            ST_CMP: begin
                r_comp   <= 1'b0;
                r_o_coll <= 1'b0;
                r_o_mx   <= '0;
                r_o_my   <= '0;
                r_o_ax   <= '0;
                r_o_bad  <= r_ovf;
                if ((r_axis == '0) || (unsigned'(ov_c) < r_best_ov)) begin
                    r_best_ov  <= unsigned'(ov_c);
                    r_best_idx <= r_axis;
                    r_best_ux  <= r_ux;
                    r_best_uy  <= r_uy;
                    r_best_isb <= r_epoly;
                end
                r_axis <= r_axis + IW'(1);
                if (e_last) begin
                    r_epoly <= 1'b1;
                    r_eidx  <= '0;
                end else begin
                    r_eidx <= e_j;
                end
            end
            ST_S_M2: r_acc <= r_prod;
            ST_S_M3: r_acc <= r_acc + (r_prod <<< 32);
            ST_S_RND: begin
                r_comp  <= 1'b1;
                r_mtv_x <= s_val;
                if (r_comp) begin
                    r_o_coll <= 1'b1;
                    r_o_mx   <= r_mtv_x;
                    r_o_my   <= s_val;
                    r_o_ax   <= ax_ext[3:0];
                    r_o_bad  <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_collided  = r_o_coll;
    assign o_mtv_x     = r_o_mx;
    assign o_mtv_y     = r_o_my;
    assign o_min_axis  = r_o_ax;
    assign o_bad_input = r_o_bad;

endmodule
